[hw/rtl/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg: shared constants for the counting hash table
// Command and status codes plus the fixed field widths of the item channels.
// ----------------------------------------------------------------------------
package cht_pkg;

   localparam int KEY_BITS     = 64;
   localparam int CMD_BITS     = 3;
   localparam int STATUS_BITS  = 2;
   localparam int THRESH_BITS  = 10;
   localparam int HASH_DIGIT   = 4;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 10'd3;

   localparam logic [CMD_BITS-1:0] CMD_ADD    = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_POP    = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_QUERY  = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 3'd4;

   localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd2;

endpackage

[hw/rtl/cht_if.sv]
// ----------------------------------------------------------------------------
// cht_if: channel interfaces of the counting hash table
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cht_req_if;
   logic                              valid;
   logic                              ready;
   logic [cht_pkg::CMD_BITS-1:0]      command;
   logic [cht_pkg::KEY_BITS-1:0]      key;

   modport source (output valid, output command, output key, input ready);
   modport sink   (input valid, input command, input key, output ready);
endinterface

interface cht_rsp_if #(parameter int COUNT_BITS = 10);
   logic                              valid;
   logic                              ready;
   logic [COUNT_BITS-1:0]             entry_count;
   logic                              is_repeat;
   logic [cht_pkg::KEY_BITS-1:0]      popped_key;
   logic [cht_pkg::STATUS_BITS-1:0]   status;

   modport source (output valid, output entry_count, output is_repeat,
                   output popped_key, output status, input ready);
   modport sink   (input valid, input entry_count, input is_repeat,
                   input popped_key, input status, output ready);
endinterface

interface cht_csr_if;
   logic                              valid;
   logic                              ready;
   logic [cht_pkg::THRESH_BITS-1:0]   repeat_threshold;

   modport source (output valid, output repeat_threshold, input ready);
   modport sink   (input valid, input repeat_threshold, output ready);
endinterface

[hw/rtl/cht_ram.sv]
// ----------------------------------------------------------------------------
// cht_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle, no reset on the contents.
// ----------------------------------------------------------------------------
module cht_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[hw/rtl/cht_hash.sv]
// ----------------------------------------------------------------------------
// cht_hash: home slot of a key
// Key modulo table depth: a mask for a power-of-two depth, otherwise a
// remainder unit that takes four key bits per cycle.
// ----------------------------------------------------------------------------
module cht_hash #(
   parameter int DEPTH = 1024,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cht_pkg::KEY_BITS-1:0]  key,
   output logic                          done,
   output logic [IDX_W-1:0]              pos
);

   localparam bit IS_POW2 = ((DEPTH & (DEPTH - 1)) == 0);

   if (IS_POW2) begin : g_mask
      logic             done_ff;
      logic [IDX_W-1:0] pos_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            done_ff <= 1'b0;
         end else begin
            done_ff <= start;
         end
         if (start) begin
            pos_ff <= key[IDX_W-1:0];
         end
      end

      assign done = done_ff;
      assign pos  = pos_ff;
   end else begin : g_serial
      localparam int STEPS  = cht_pkg::KEY_BITS / cht_pkg::HASH_DIGIT;
      localparam int STEP_W = $clog2(STEPS);
      localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);
      localparam logic [IDX_W:0]    DEPTH_EXT = (IDX_W + 1)'(DEPTH);

      logic                          busy_ff;
      logic                          done_ff;
      logic [STEP_W-1:0]             step_ff;
      logic [cht_pkg::KEY_BITS-1:0]  shift_ff;
      logic [IDX_W-1:0]              rem_ff;
      logic [IDX_W:0]                rem_in;
      logic [cht_pkg::HASH_DIGIT-1:0] digit;

      assign digit = shift_ff[cht_pkg::KEY_BITS-1 -: cht_pkg::HASH_DIGIT];

      // one compare-subtract per key bit, msb first
      always_comb begin
         rem_in = {1'b0, rem_ff};
         for (int i = cht_pkg::HASH_DIGIT - 1; i >= 0; i--) begin
            rem_in = {rem_in[IDX_W-1:0], digit[i]};
            if (rem_in >= DEPTH_EXT) begin
               rem_in = rem_in - DEPTH_EXT;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b0;
            step_ff <= '0;
         end else begin
            done_ff <= 1'b0;
            if (start) begin
               busy_ff <= 1'b1;
               step_ff <= '0;
            end else if (busy_ff) begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         end
         if (start) begin
            shift_ff <= key;
            rem_ff   <= '0;
         end else if (busy_ff) begin
            shift_ff <= shift_ff << cht_pkg::HASH_DIGIT;
            rem_ff   <= rem_in[IDX_W-1:0];
         end
      end

      assign done = done_ff;
      assign pos  = rem_ff;
   end

endmodule

[hw/rtl/counting_hash_table_with_history_unit.sv]
// ----------------------------------------------------------------------------
// counting_hash_table_with_history_unit: counting multiset of 64-bit keys
// Open-addressed table with linear probing and a history stack of added keys.
// ----------------------------------------------------------------------------
// add, remove and query hash the key (a mask with a power-of-two table depth,
//   the remainder unit otherwise), then compare slots in probe order.
// pop first reads the key from the history; clear zeroes every table slot.
// throughput: one item at a time, as requests are taken only in the idle state;
//   the probe walks the single table read port one slot per cycle.
// reset: a clearing pass zeroes the table, no item taken.
module counting_hash_table_with_history_unit #(
   parameter int TABLE_DEPTH   = 1024,
   parameter int HISTORY_DEPTH = 512,
   parameter int COUNT_BITS    = 10
) (
   input  logic      clock,
   input  logic      reset,
   cht_req_if.sink   req_chan,
   cht_rsp_if.source rsp_chan,
   cht_csr_if.sink   csr_chan
);

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int HA_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int ENTRY_W = cht_pkg::KEY_BITS + COUNT_BITS;
   localparam int CMP_W   = (COUNT_BITS > cht_pkg::THRESH_BITS) ?
                            COUNT_BITS : cht_pkg::THRESH_BITS;

   localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [FILL_W-1:0]     HIST_FULL = FILL_W'(HISTORY_DEPTH);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HIST,
      S_HASH,
      S_CMP,
      S_DONE
   } state_type;

   state_type                           state_ff;
   logic [IDX_W-1:0]                    clr_idx_ff;
   logic                                clr_rsp_ff;
   logic [cht_pkg::CMD_BITS-1:0]        cmd_ff;
   logic [cht_pkg::KEY_BITS-1:0]        key_ff;
   logic [IDX_W-1:0]                    pos_ff;
   logic [IDX_W-1:0]                    probe_ff;
   logic [FILL_W-1:0]                   fill_ff;
   logic [cht_pkg::THRESH_BITS-1:0]     thr_ff;

   logic [COUNT_BITS-1:0]               res_count_ff;
   logic                                res_repeat_ff;
   logic [cht_pkg::KEY_BITS-1:0]        res_popped_ff;
   logic [cht_pkg::STATUS_BITS-1:0]     res_status_ff;

   logic                                rsp_valid_ff;
   logic [COUNT_BITS-1:0]               out_count_ff;
   logic                                out_repeat_ff;
   logic [cht_pkg::KEY_BITS-1:0]        out_popped_ff;
   logic [cht_pkg::STATUS_BITS-1:0]     out_status_ff;

   logic                                req_acc;
   logic [cht_pkg::KEY_BITS-1:0]        slot_key;
   logic [COUNT_BITS-1:0]               slot_count;
   logic                                slot_hit;
   logic [IDX_W-1:0]                    pos_nxt;
   logic [COUNT_BITS-1:0]               cnt_up;
   logic [COUNT_BITS-1:0]               cnt_dn;
   logic                                hit_repeat;
   logic [FILL_W-1:0]                   fill_dec;

   logic                                tbl_wr_en;
   logic [IDX_W-1:0]                    tbl_wr_addr;
   logic [ENTRY_W-1:0]                  tbl_wr_data;
   logic [IDX_W-1:0]                    tbl_rd_addr;
   logic [ENTRY_W-1:0]                  tbl_rd_data;

   logic                                hist_wr_en;
   logic [HA_W-1:0]                     hist_wr_addr;
   logic [HA_W-1:0]                     hist_rd_addr;
   logic [cht_pkg::KEY_BITS-1:0]        hist_rd_data;

   logic                                hash_start;
   logic [cht_pkg::KEY_BITS-1:0]        hash_key;
   logic                                hash_done;
   logic [IDX_W-1:0]                    hash_pos;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign slot_key   = tbl_rd_data[ENTRY_W-1:COUNT_BITS];
   assign slot_count = tbl_rd_data[COUNT_BITS-1:0];
   // an empty slot ends the probe as well as a matching key
   assign slot_hit   = (slot_count == '0) || (slot_key == key_ff);
   assign pos_nxt    = (pos_ff == LAST_IDX) ? '0 : pos_ff + 1'b1;
   assign cnt_up     = (slot_count == COUNT_MAX) ? slot_count : slot_count + 1'b1;
   assign cnt_dn     = (slot_count == '0) ? '0 : slot_count - 1'b1;
   assign hit_repeat = CMP_W'(slot_count) >= CMP_W'(thr_ff);
   assign fill_dec   = fill_ff - 1'b1;

   // history: push on add when there is room, read below the fill on pop
   assign hist_wr_en   = req_acc && (req_chan.command == cht_pkg::CMD_ADD) &&
                         (fill_ff != HIST_FULL);
   assign hist_wr_addr = fill_ff[HA_W-1:0];
   assign hist_rd_addr = fill_dec[HA_W-1:0];

   assign hash_start = (req_acc && ((req_chan.command == cht_pkg::CMD_ADD) ||
                                    (req_chan.command == cht_pkg::CMD_REMOVE) ||
                                    (req_chan.command == cht_pkg::CMD_QUERY))) ||
                       (state_ff == S_HIST);
   assign hash_key   = (state_ff == S_HIST) ? hist_rd_data : req_chan.key;

   // next probe read is issued while the current slot is compared
   assign tbl_rd_addr = (state_ff == S_CMP) ? pos_nxt : hash_pos;

   always_comb begin
      tbl_wr_en   = 1'b0;
      tbl_wr_addr = pos_ff;
      tbl_wr_data = {slot_key, cnt_dn};
      if (state_ff == S_CLEAR) begin
         tbl_wr_en   = 1'b1;
         tbl_wr_addr = clr_idx_ff;
         tbl_wr_data = '0;
      end else if ((state_ff == S_CMP) && slot_hit) begin
         tbl_wr_en = (cmd_ff != cht_pkg::CMD_QUERY);
         if (cmd_ff == cht_pkg::CMD_ADD) begin
            tbl_wr_data = {key_ff, cnt_up};
         end
      end
   end

   cht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   cht_ram #(
      .WIDTH (cht_pkg::KEY_BITS),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (req_chan.key),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   cht_hash #(
      .DEPTH (TABLE_DEPTH)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (hash_key),
      .done  (hash_done),
      .pos   (hash_pos)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         fill_ff      <= '0;
         thr_ff       <= cht_pkg::THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            thr_ff <= csr_chan.repeat_threshold;
         end
         // in the done state the output register is reloaded below
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               if (clr_idx_ff == LAST_IDX) begin
                  clr_idx_ff <= '0;
                  clr_rsp_ff <= 1'b0;
                  state_ff   <= clr_rsp_ff ? S_DONE : S_IDLE;
               end else begin
                  clr_idx_ff <= clr_idx_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_acc) begin
                  cmd_ff        <= req_chan.command;
                  key_ff        <= req_chan.key;
                  res_count_ff  <= '0;
                  res_repeat_ff <= 1'b0;
                  res_popped_ff <= '0;
                  res_status_ff <= cht_pkg::STAT_OK;
                  case (req_chan.command)
                     cht_pkg::CMD_ADD: begin
                        if (fill_ff != HIST_FULL) begin
                           fill_ff <= fill_ff + 1'b1;
                        end
                        state_ff <= S_HASH;
                     end
                     cht_pkg::CMD_REMOVE, cht_pkg::CMD_QUERY: begin
                        state_ff <= S_HASH;
                     end
                     cht_pkg::CMD_POP: begin
                        if (fill_ff == '0) begin
                           res_status_ff <= cht_pkg::STAT_EMPTY;
                           state_ff      <= S_DONE;
                        end else begin
                           fill_ff  <= fill_dec;
                           state_ff <= S_HIST;
                        end
                     end
                     cht_pkg::CMD_CLEAR: begin
                        fill_ff    <= '0;
                        clr_rsp_ff <= 1'b1;
                        state_ff   <= S_CLEAR;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_HIST: begin
               key_ff        <= hist_rd_data;
               res_popped_ff <= hist_rd_data;
               state_ff      <= S_HASH;
            end
            S_HASH: begin
               if (hash_done) begin
                  pos_ff   <= hash_pos;
                  probe_ff <= '0;
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               if (slot_hit) begin
                  case (cmd_ff)
                     cht_pkg::CMD_ADD: begin
                        res_count_ff <= cnt_up;
                     end
                     cht_pkg::CMD_REMOVE, cht_pkg::CMD_POP: begin
                        res_count_ff <= cnt_dn;
                     end
                     cht_pkg::CMD_QUERY: begin
                        res_count_ff  <= slot_count;
                        res_repeat_ff <= hit_repeat;
                     end
                     default: begin
                        res_count_ff <= '0;
                     end
                  endcase
                  state_ff <= S_DONE;
               end else if (probe_ff == LAST_IDX) begin
                  // full sweep without the key or a free slot
                  res_status_ff <= cht_pkg::STAT_FULL;
                  res_repeat_ff <= (cmd_ff == cht_pkg::CMD_QUERY) && (thr_ff == '0);
                  state_ff      <= S_DONE;
               end else begin
                  pos_ff   <= pos_nxt;
                  probe_ff <= probe_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  out_count_ff  <= res_count_ff;
                  out_repeat_ff <= res_repeat_ff;
                  out_popped_ff <= res_popped_ff;
                  out_status_ff <= res_status_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.entry_count = out_count_ff;
   assign rsp_chan.is_repeat   = out_repeat_ff;
   assign rsp_chan.popped_key  = out_popped_ff;
   assign rsp_chan.status      = out_status_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= HIST_FULL)
      else $error("history fill beyond depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_chan.ready)
      else $error("item accepted while previous one in progress");

   a_hash_in_step: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == S_HASH))
      else $error("hash result outside hash wait");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_chan.command == cht_pkg::CMD_CLEAR)
      |=> (fill_ff == '0) && (state_ff == S_CLEAR))
      else $error("clear did not empty history");

   a_no_write_on_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) && (cmd_ff == cht_pkg::CMD_QUERY) |-> !tbl_wr_en)
      else $error("query modified table");
`endif

endmodule

[verif/counting_hash_table_with_history_unit_test.sv]
// ----------------------------------------------------------------------------
// counting_hash_table_with_history_unit_test: self-checking bench
// Drives add, remove, pop, query, clear and unused commands through the
// request channel. A local copy of the table, history stack and threshold
// predicts each answer, which is compared field by field in arrival order.
// Runs directed corner cases, threshold extremes, count saturation, a full
// table with full history, then random traffic over colliding key pools.
// ----------------------------------------------------------------------------
module counting_hash_table_with_history_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_BITS         = cht_pkg::KEY_BITS;
   localparam int CMD_BITS         = cht_pkg::CMD_BITS;
   localparam int STATUS_BITS      = cht_pkg::STATUS_BITS;
   localparam int THRESH_BITS      = cht_pkg::THRESH_BITS;
   localparam int TABLE_DEPTH      = 1024;
   localparam int HISTORY_DEPTH    = 512;
   localparam int COUNT_BITS       = 10;
   localparam int SLOT_BITS        = $clog2(TABLE_DEPTH);
   localparam int POOL_SIZE        = 32;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 64;

   localparam logic [COUNT_BITS-1:0]  COUNT_MAX        = '1;
   localparam logic [THRESH_BITS-1:0] THRESH_MAX       = '1;
   localparam logic [CMD_BITS-1:0]    CMD_UNUSED_FIRST = 3'd5;
   localparam logic [CMD_BITS-1:0]    CMD_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [COUNT_BITS-1:0]  entry_count;
      logic                   is_repeat;
      logic [KEY_BITS-1:0]    popped_key;
      logic [STATUS_BITS-1:0] status;
   } table_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cht_req_if                              req_chan();
   cht_rsp_if #(.COUNT_BITS(COUNT_BITS))   rsp_chan();
   cht_csr_if                              csr_chan();

   counting_hash_table_with_history_unit #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .COUNT_BITS    (COUNT_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // shadow of the table, the history stack and the threshold
   logic [KEY_BITS-1:0]    slot_key    [TABLE_DEPTH];
   logic [COUNT_BITS-1:0]  slot_count  [TABLE_DEPTH];
   logic [KEY_BITS-1:0]    history_key [HISTORY_DEPTH];
   int                     history_used;
   logic [THRESH_BITS-1:0] threshold;

   table_answer_type    pending_answers[$];
   logic [KEY_BITS-1:0] key_pool[POOL_SIZE];
   int                  mismatch_count;
   bit                  idling_on;
   bit                  hold_off_request;
   int                  stall_left;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   initial begin
      req_chan.valid            = 1'b0;
      req_chan.command          = cht_pkg::CMD_QUERY;
      req_chan.key              = '0;
      rsp_chan.ready            = 1'b0;
      csr_chan.valid            = 1'b0;
      csr_chan.repeat_threshold = cht_pkg::THRESH_RESET;
      foreach (slot_count[i]) slot_count[i] = '0;
      foreach (slot_key[i]) slot_key[i] = '0;
      foreach (history_key[i]) history_key[i] = '0;
      history_used     = 0;
      threshold        = cht_pkg::THRESH_RESET;
      mismatch_count   = 0;
      idling_on        = 1'b1;
      hold_off_request = 1'b0;
      stall_left       = 0;
   end

   // ---------------------------------------------------------------- predictor

   // linear probe from the home slot; -1 when a full sweep finds nothing usable
   function automatic int locate_slot(input logic [KEY_BITS-1:0] key);
      int pos;
      pos = int'(key % 64'(TABLE_DEPTH));
      for (int n = 0; n < TABLE_DEPTH; n++) begin
         if (slot_count[pos] == '0 || slot_key[pos] == key) return pos;
         pos = (pos + 1) % TABLE_DEPTH;
      end
      return -1;
   endfunction

   function automatic void count_down(input logic [KEY_BITS-1:0] key,
                                      inout table_answer_type answer);
      int slot;
      slot = locate_slot(key);
      if (slot < 0) begin
         answer.status = cht_pkg::STAT_FULL;
      end else begin
         if (slot_count[slot] != '0) slot_count[slot]--;
         answer.entry_count = slot_count[slot];
      end
   endfunction

   function automatic void predict_table_op(input logic [CMD_BITS-1:0] cmd,
                                            input logic [KEY_BITS-1:0] key);
      table_answer_type answer;
      int               slot;
      answer = '0;
      case (cmd)
         cht_pkg::CMD_ADD: begin
            slot = locate_slot(key);
            if (slot < 0) begin
               answer.status = cht_pkg::STAT_FULL;
            end else begin
               if (slot_count[slot] == '0) slot_key[slot] = key;
               if (slot_count[slot] != COUNT_MAX) slot_count[slot]++;
               answer.entry_count = slot_count[slot];
            end
            if (history_used < HISTORY_DEPTH) begin
               history_key[history_used] = key;
               history_used++;
            end
         end
         cht_pkg::CMD_REMOVE: count_down(key, answer);
         cht_pkg::CMD_POP: begin
            if (history_used == 0) begin
               answer.status = cht_pkg::STAT_EMPTY;
            end else begin
               history_used--;
               answer.popped_key = history_key[history_used];
               count_down(answer.popped_key, answer);
            end
         end
         cht_pkg::CMD_QUERY: begin
            slot = locate_slot(key);
            if (slot < 0) answer.status = cht_pkg::STAT_FULL;
            else answer.entry_count = slot_count[slot];
            answer.is_repeat = (answer.entry_count >= threshold);
         end
         cht_pkg::CMD_CLEAR: begin
            foreach (slot_count[i]) slot_count[i] = '0;
            history_used = 0;
         end
         default: ;
      endcase
      pending_answers.push_back(answer);
   endfunction

   // ---------------------------------------------------------------- channels

   // entered and left at a rising edge
   task automatic send_item(input logic [CMD_BITS-1:0] cmd,
                            input logic [KEY_BITS-1:0] key);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.command <= cmd;
      req_chan.key     <= key;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_table_op(cmd, key);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // only called with nothing in flight
   task automatic write_threshold(input logic [THRESH_BITS-1:0] value);
      csr_chan.valid            <= 1'b1;
      csr_chan.repeat_threshold <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      threshold = value;
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // result side: random stall bursts, or one long hold-off
   always @(posedge clock) begin
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         stall_left       = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      table_answer_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: answer expected none actual count %0h status %0h",
                     $time, rsp_chan.entry_count, rsp_chan.status);
            mismatch_count++;
         end else begin
            want = pending_answers.pop_front();
            check_field("entry_count", 64'(want.entry_count), 64'(rsp_chan.entry_count));
            check_field("is_repeat", 64'(want.is_repeat), 64'(rsp_chan.is_repeat));
            check_field("popped_key", want.popped_key, rsp_chan.popped_key);
            check_field("status", 64'(want.status), 64'(rsp_chan.status));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [KEY_BITS-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed();
      logic [KEY_BITS-1:0] key_a;
      logic [KEY_BITS-1:0] key_b;
      key_a = 64'h8000_0000_0000_0005;
      key_b = key_a + 64'(TABLE_DEPTH);
      send_item(cht_pkg::CMD_QUERY, '0);
      send_item(cht_pkg::CMD_POP, '0);
      send_item(cht_pkg::CMD_REMOVE, '0);
      send_item(cht_pkg::CMD_ADD, '0);
      repeat (3) send_item(cht_pkg::CMD_ADD, '1);
      send_item(cht_pkg::CMD_QUERY, '1);
      // same home as all ones, wraps past slot zero
      send_item(cht_pkg::CMD_ADD, 64'h7FF);
      send_item(cht_pkg::CMD_ADD, key_a);
      send_item(cht_pkg::CMD_ADD, key_b);
      // emptying key_a's slot cuts the chain to key_b
      send_item(cht_pkg::CMD_REMOVE, key_a);
      send_item(cht_pkg::CMD_QUERY, key_b);
      send_item(cht_pkg::CMD_ADD, key_b);
      send_item(cht_pkg::CMD_REMOVE, key_b);
      repeat (3) send_item(cht_pkg::CMD_POP, '0);
      send_item(CMD_UNUSED_FIRST, '1);
      send_item(CMD_UNUSED_FIRST + 3'd1, key_a);
      send_item(CMD_UNUSED_LAST, '0);
      send_item(cht_pkg::CMD_CLEAR, '1);
      send_item(cht_pkg::CMD_POP, key_a);
      send_item(cht_pkg::CMD_QUERY, '1);
      send_item(cht_pkg::CMD_ADD, key_a);
   endtask

   task automatic test_threshold_extremes();
      logic [KEY_BITS-1:0] key;
      key = random_key();
      wait_drained();
      write_threshold('0);
      send_item(cht_pkg::CMD_QUERY, random_key());
      send_item(cht_pkg::CMD_ADD, key);
      send_item(cht_pkg::CMD_QUERY, key);
      wait_drained();
      write_threshold(THRESH_MAX);
      send_item(cht_pkg::CMD_QUERY, key);
      wait_drained();
      write_threshold(10'd1);
      send_item(cht_pkg::CMD_QUERY, key);
   endtask

   task automatic test_count_saturation();
      logic [KEY_BITS-1:0] key;
      key = random_key();
      send_item(cht_pkg::CMD_CLEAR, '0);
      // history fills half way through, count pins at its maximum
      repeat (int'(COUNT_MAX) + 2) send_item(cht_pkg::CMD_ADD, key);
      wait_drained();
      write_threshold(THRESH_MAX);
      send_item(cht_pkg::CMD_QUERY, key);
      send_item(cht_pkg::CMD_REMOVE, key);
      send_item(cht_pkg::CMD_QUERY, key);
      send_item(cht_pkg::CMD_POP, '0);
   endtask

   task automatic test_full_table();
      logic [KEY_BITS-1:0] fill_key[TABLE_DEPTH];
      logic [KEY_BITS-1:0] absent;
      foreach (fill_key[i]) begin
         fill_key[i] = random_key();
         fill_key[i][SLOT_BITS-1:0] = SLOT_BITS'(i);
      end
      // each key sits in its own home slot, so flipping a high bit misses all
      absent = fill_key[$urandom_range(0, TABLE_DEPTH - 1)] ^ (64'h1 << 40);
      wait_drained();
      write_threshold(10'd2);
      send_item(cht_pkg::CMD_CLEAR, '0);
      hold_off_request = 1'b1;
      for (int i = 0; i < HISTORY_DEPTH; i++) send_item(cht_pkg::CMD_ADD, fill_key[i]);
      for (int i = 0; i < HISTORY_DEPTH; i++) send_item(cht_pkg::CMD_ADD, fill_key[i]);
      for (int i = HISTORY_DEPTH; i < TABLE_DEPTH; i++) begin
         send_item(cht_pkg::CMD_ADD, fill_key[i]);
      end
      // free one history entry without emptying a slot
      send_item(cht_pkg::CMD_POP, '0);
      send_item(cht_pkg::CMD_ADD, absent);
      send_item(cht_pkg::CMD_QUERY, absent);
      send_item(cht_pkg::CMD_REMOVE, absent);
      send_item(cht_pkg::CMD_POP, '0);
      send_item(cht_pkg::CMD_ADD, fill_key[TABLE_DEPTH - 1]);
      send_item(cht_pkg::CMD_QUERY, fill_key[0]);
      wait_drained();
      write_threshold('0);
      send_item(cht_pkg::CMD_QUERY, absent);
      send_item(cht_pkg::CMD_CLEAR, '0);
   endtask

   // colliding keys around the wrap point and two random home slots
   task automatic build_pool();
      int home[4];
      home[0] = TABLE_DEPTH - 2;
      home[1] = TABLE_DEPTH - 1;
      home[2] = $urandom_range(0, TABLE_DEPTH - 1);
      home[3] = $urandom_range(0, TABLE_DEPTH - 1);
      foreach (key_pool[i]) begin
         key_pool[i] = random_key();
         key_pool[i][SLOT_BITS-1:0] = SLOT_BITS'(home[i % 4]);
      end
   endtask

   task automatic run_random_items(input int count);
      logic [CMD_BITS-1:0] cmd;
      logic [KEY_BITS-1:0] key;
      int                  pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         key  = ($urandom_range(0, 7) == 0) ? random_key()
                                            : key_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (pick < 38) cmd = cht_pkg::CMD_ADD;
         else if (pick < 56) cmd = cht_pkg::CMD_REMOVE;
         else if (pick < 70) cmd = cht_pkg::CMD_POP;
         else if (pick < 95) cmd = cht_pkg::CMD_QUERY;
         else if (pick < 96) cmd = cht_pkg::CMD_CLEAR;
         else cmd = CMD_BITS'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
         send_item(cmd, key);
      end
   endtask

   task automatic test_random_traffic();
      build_pool();
      wait_drained();
      write_threshold(THRESH_BITS'($urandom_range(1, 4)));
      run_random_items(450);
      wait_drained();
      write_threshold(THRESH_BITS'($urandom_range(1, 6)));
      hold_off_request = 1'b1;
      run_random_items(450);
   endtask

   task automatic test_random_steady();
      idling_on = 1'b0;
      build_pool();
      run_random_items(150);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_threshold_extremes();
      test_count_saturation();
      test_full_table();
      test_random_traffic();
      test_random_steady();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
